>>> rtl/sps_pkg.sv
// Package: shared constants, payload types and state codes of the shortest path search.
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

  localparam int NUM_VERTICES = 16;
  localparam int NODE_W       = 4;
  localparam int WEIGHT_W     = 7;
  localparam int COST_W       = 11;
  localparam int MAX_OUT      = 16;
  localparam int K_W          = $clog2(MAX_OUT);
  localparam int ROW_W        = NUM_VERTICES * WEIGHT_W;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]          kind;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0] path_node;
    logic [COST_W-1:0] total_cost;
    logic              found;
    logic              last;
  } out_t;

  typedef struct packed {
    logic              settled;
    logic              reached;
    logic [NODE_W-1:0] pred;
    logic [COST_W-1:0] cost;
  } vent_t;

  localparam int VENT_W = $bits(vent_t);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADD_WR, ST_INIT, ST_SCAN, ST_SCAN_END, ST_PICK, ST_ROW,
    ST_RELAX, ST_RELAX_END, ST_WALK_RD, ST_WALK_OUT, ST_NOROUTE
  } state_e;

endpackage
`default_nettype wire

>>> rtl/sps_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/sps_out_stage.sv
// Output register holding one result transaction until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module sps_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire sps_pkg::out_t data_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sps_pkg::out_t      out_data_o
);
  import sps_pkg::*;

  logic valid_q;
  out_t data_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/shortest_path_search.sv
// Top level: edge matrix and vertex table RAMs with the search sequencer.
// Edge add: row read on acceptance, then row write. Clear and unused kinds: done on acceptance.
// Query: vertex table init, then per settled vertex a scan of the table plus a row
// relaxation, cut short at the end vertex or when no reached vertex is left.
// Route output: per result vertex, a vertex table read, then an output load.
// Reset clears row valid bits, so the graph reads as empty at once.
`timescale 1ns / 1ps
`default_nettype none
module shortest_path_search (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sps_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sps_pkg::out_t      out_data_o
);
  import sps_pkg::*;

  localparam int VA_W = $clog2(NUM_VERTICES);

  state_e state_q, state_d;

  logic [NODE_W-1:0]       src_q, dst_q, add_a_q, add_b_q;
  logic [WEIGHT_W-1:0]     add_w_q;
  logic [VA_W-1:0]         cnt_q, vidx_q, pick_q;
  logic                    vld_q, have_q;
  logic [COST_W-1:0]       pcost_q, total_q;
  logic [NODE_W-1:0]       ppred_q, v_q;
  logic [K_W-1:0]          k_q;
  logic [ROW_W-1:0]        row_q;
  logic [NUM_VERTICES-1:0] row_valid_q;

  logic              ewe, ere, vwe, vre;
  logic [VA_W-1:0]   ewaddr, eraddr, vwaddr, vraddr;
  logic [ROW_W-1:0]  ewdata, erdata, old_row;
  logic [VENT_W-1:0] vwdata_raw, vrdata_raw;
  vent_t             vwdata, vr;

  logic                accept, add_ok, q_ok, cnt_last, walk_last;
  logic                scan_better, relax_upd, out_free, out_load;
  logic [WEIGHT_W-1:0] relax_c, old_c;
  logic [COST_W:0]     tent;
  out_t                out_d;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign add_ok     = (in_data_i.weight != '0) &&
                      (int'(in_data_i.node_a) < NUM_VERTICES) &&
                      (int'(in_data_i.node_b) < NUM_VERTICES);
  assign q_ok       = (int'(in_data_i.node_a) < NUM_VERTICES) &&
                      (int'(in_data_i.node_b) < NUM_VERTICES);
  assign cnt_last   = (cnt_q == VA_W'(NUM_VERTICES - 1));
  assign walk_last  = (v_q == src_q) || (k_q == K_W'(MAX_OUT - 1));

  assign vr          = vent_t'(vrdata_raw);
  assign vwdata_raw  = vwdata;
  assign scan_better = vld_q && !vr.settled && vr.reached &&
                       (!have_q || vr.cost < pcost_q);
  assign relax_c     = row_q[vidx_q*WEIGHT_W +: WEIGHT_W];
  assign tent        = {1'b0, pcost_q} + {{(COST_W+1-WEIGHT_W){1'b0}}, relax_c};
  assign relax_upd   = vld_q && (relax_c != '0) && !vr.settled &&
                       (!vr.reached || tent < {1'b0, vr.cost});

  assign old_row = row_valid_q[add_a_q[VA_W-1:0]] ? erdata : '0;
  assign old_c   = old_row[add_b_q[VA_W-1:0]*WEIGHT_W +: WEIGHT_W];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.kind)
            KIND_ADD:   state_d = add_ok ? ST_ADD_WR : ST_IDLE;
            KIND_QUERY: state_d = q_ok ? ST_INIT : ST_NOROUTE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_WR:    state_d = ST_IDLE;
      ST_INIT:      state_d = cnt_last ? ST_SCAN : ST_INIT;
      ST_SCAN:      state_d = cnt_last ? ST_SCAN_END : ST_SCAN;
      ST_SCAN_END:  state_d = ST_PICK;
      ST_PICK: begin
        if (!have_q) begin
          state_d = ST_NOROUTE;
        end else if (NODE_W'(pick_q) == dst_q) begin
          state_d = ST_WALK_RD;
        end else begin
          state_d = ST_ROW;
        end
      end
      ST_ROW:       state_d = ST_RELAX;
      ST_RELAX:     state_d = cnt_last ? ST_RELAX_END : ST_RELAX;
      ST_RELAX_END: state_d = ST_SCAN;
      ST_WALK_RD:   state_d = ST_WALK_OUT;
      ST_WALK_OUT: begin
        if (out_free) begin
          state_d = walk_last ? ST_IDLE : ST_WALK_RD;
        end
      end
      ST_NOROUTE:   state_d = out_free ? ST_IDLE : ST_NOROUTE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ere    = 1'b0;
    eraddr = in_data_i.node_a[VA_W-1:0];
    ewe    = 1'b0;
    ewaddr = add_a_q[VA_W-1:0];
    ewdata = old_row;
    vwe    = 1'b0;
    vwaddr = cnt_q;
    vwdata = '0;
    vre    = 1'b0;
    vraddr = cnt_q;
    out_load = 1'b0;
    out_d    = '0;
    unique case (state_q)
      ST_IDLE: begin
        ere = accept && (in_data_i.kind == KIND_ADD);
      end
      ST_ADD_WR: begin
        ewe = 1'b1;
        if (old_c == '0 || add_w_q < old_c) begin
          ewdata[add_b_q[VA_W-1:0]*WEIGHT_W +: WEIGHT_W] = add_w_q;
        end
      end
      ST_INIT: begin
        vwe = 1'b1;
        if (NODE_W'(cnt_q) == src_q) begin
          vwdata = '{settled: 1'b0, reached: 1'b1, pred: src_q, cost: '0};
        end
      end
      ST_SCAN: vre = 1'b1;
      ST_PICK: begin
        ere    = 1'b1;
        eraddr = pick_q;
        vwe    = have_q;
        vwaddr = pick_q;
        vwdata = '{settled: 1'b1, reached: 1'b1, pred: ppred_q, cost: pcost_q};
      end
      ST_RELAX, ST_RELAX_END: begin
        vre    = (state_q == ST_RELAX);
        vwe    = relax_upd;
        vwaddr = vidx_q;
        vwdata = '{settled: 1'b0, reached: 1'b1, pred: NODE_W'(pick_q),
                   cost: tent[COST_W-1:0]};
      end
      ST_WALK_RD: begin
        vre    = 1'b1;
        vraddr = v_q[VA_W-1:0];
      end
      ST_WALK_OUT: begin
        out_load = out_free;
        out_d    = '{path_node: v_q, total_cost: total_q, found: 1'b1,
                     last: walk_last};
      end
      ST_NOROUTE: begin
        out_load = out_free;
        out_d    = '{path_node: '0, total_cost: '0, found: 1'b0, last: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      vld_q       <= 1'b0;
      have_q      <= 1'b0;
      row_valid_q <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= (state_q == ST_SCAN) || (state_q == ST_RELAX);
      if (state_q == ST_INIT || state_q == ST_SCAN || state_q == ST_RELAX) begin
        cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
      end
      if (state_q == ST_INIT || state_q == ST_RELAX_END) begin
        have_q <= 1'b0;
      end else if ((state_q == ST_SCAN || state_q == ST_SCAN_END) && scan_better) begin
        have_q <= 1'b1;
      end
      if (accept && in_data_i.kind == KIND_CLEAR) begin
        row_valid_q <= '0;
      end else if (state_q == ST_ADD_WR) begin
        row_valid_q[add_a_q[VA_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vidx_q <= cnt_q;
    if (accept) begin
      add_a_q <= in_data_i.node_a;
      add_b_q <= in_data_i.node_b;
      add_w_q <= in_data_i.weight;
      src_q   <= in_data_i.node_a;
      dst_q   <= in_data_i.node_b;
    end
    if ((state_q == ST_SCAN || state_q == ST_SCAN_END) && scan_better) begin
      pick_q  <= vidx_q;
      pcost_q <= vr.cost;
      ppred_q <= vr.pred;
    end
    if (state_q == ST_ROW) begin
      row_q <= row_valid_q[pick_q] ? erdata : '0;
    end
    if (state_q == ST_PICK) begin
      total_q <= pcost_q;
      v_q     <= dst_q;
      k_q     <= '0;
    end else if (state_q == ST_WALK_OUT && out_free && !walk_last) begin
      v_q <= vr.pred;
      k_q <= k_q + 1'b1;
    end
  end

  sps_ram #(.WIDTH(ROW_W), .DEPTH(NUM_VERTICES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ewe),
    .waddr_i (ewaddr),
    .wdata_i (ewdata),
    .re_i    (ere),
    .raddr_i (eraddr),
    .rdata_o (erdata)
  );

  sps_ram #(.WIDTH(VENT_W), .DEPTH(NUM_VERTICES)) u_vert_ram (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (vwaddr),
    .wdata_i (vwdata_raw),
    .re_i    (vre),
    .raddr_i (vraddr),
    .rdata_o (vrdata_raw)
  );

  sps_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .data_i      (out_d),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vwe && vre |-> vwaddr != vraddr)
    else $error("vertex table read and write hit the same entry");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_valid_o |-> out_ready_i)
    else $error("result loaded over a pending transaction");

  a_query_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.kind == KIND_QUERY |=>
      state_q == ST_INIT || state_q == ST_NOROUTE)
    else $error("query did not start");

endmodule
`default_nettype wire
